/* rtl/llps_pkg.sv */
// Package for the light level pattern sequencer: constants, opcodes, command/status types.
// Used by llps_ctrl, llps_datapath and light_level_pattern_sequencer.
package llps_pkg;

    localparam int USER_STYLES_DEF = 16;
    localparam int ALL_STYLES_DEF  = 64;
    localparam int PATTERN_LEN_DEF = 64;
    localparam int FRAC_BITS_DEF   = 12;
    localparam int MAX_LEAVES_DEF  = 16;

    localparam int RESULT_MAX  = 16;
    localparam int DARK_STYLE  = 64;
    localparam int LEVEL_MAX   = 400;
    localparam int LEVEL_STEP  = 22;
    localparam int EMPTY_LEVEL = 256;
    localparam int FLASH_BOOST = 8'h80;
    localparam int LIGHT_MAX   = 8'hFF;
    localparam int TIME_SCALE  = 10;

    localparam logic [2:0] OP_LOAD   = 3'd0;
    localparam logic [2:0] OP_DIRECT = 3'd1;
    localparam logic [2:0] OP_TICK   = 3'd2;
    localparam logic [2:0] OP_LEAF   = 3'd3;
    localparam logic [2:0] OP_ENTITY = 3'd4;

    // Commands from controller to datapath.
    typedef struct packed {
        logic capture;     // register the accepted transaction
        logic do_load;     // write letter / length
        logic do_direct;   // write direct level
        logic tick_start;  // compute step, reset style counter
        logic mem_read;    // issue pattern read for current style
        logic div_start;   // start modulo of step by length
        logic div_step;    // one restoring division step
        logic tick_write;  // write level of current style, advance
        logic leaf_mul;    // register products
        logic leaf_acc;    // accumulate sum
        logic avg_start;   // start averaging division
        logic out_style;   // load output with current style level
        logic out_entity;  // load output with entity light
        logic out_avg;     // load output with average
    } llps_cmd_t;

    typedef struct packed {
        logic [2:0] opcode;
        logic       final_leaf;
        logic       div_done;
        logic       style_last;  // current style is the last user style
        logic       emit_last;   // current emitted style is the last one
        logic       emit_ok;     // current style is below the result limit
    } llps_stat_t;

    function automatic logic [8:0] letter_level(input logic [4:0] letter);
        logic [9:0] k;
        k = 10'(letter) * 10'(LEVEL_STEP);
        letter_level = (k > 10'(LEVEL_MAX)) ? 9'(LEVEL_MAX) : k[8:0];
    endfunction

endpackage

/* rtl/light_level_pattern_sequencer.sv */
// Top level of the light level pattern sequencer: controller plus datapath.
// Depends on llps_pkg, llps_ctrl and llps_datapath.
//
//  channel | ports                      | direction
//  input   | s_valid, s_ready, s_<field>| in
//  result  | m_valid, m_ready, m_<field>| out
//
// A tick runs the shared bit-serial divider for step mod length for each user style
// with a pattern and skips it for a user style with an empty pattern; the final leaf
// of a leaf sample adds the averaging division on the same divider.
// Reset (aresetn, synchronous) clears lengths, level valid flags, pointers and leaf sums.
// A stalled result holds the block until it is taken.
module light_level_pattern_sequencer #(
    parameter int USER_STYLES = llps_pkg::USER_STYLES_DEF,
    parameter int ALL_STYLES  = llps_pkg::ALL_STYLES_DEF,
    parameter int PATTERN_LEN = llps_pkg::PATTERN_LEN_DEF,
    parameter int FRAC_BITS   = llps_pkg::FRAC_BITS_DEF,
    parameter int MAX_LEAVES  = llps_pkg::MAX_LEAVES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_opcode,
    input  logic [5:0]  s_style_index,
    input  logic [4:0]  s_pattern_level,
    input  logic        s_pattern_end,
    input  logic [27:0] s_tick_time,
    input  logic [7:0]  s_lightmap_a,
    input  logic [6:0]  s_leaf_style_a,
    input  logic [7:0]  s_lightmap_b,
    input  logic [6:0]  s_leaf_style_b,
    input  logic        s_leaf_final,
    input  logic        s_flash_flag,
    input  logic [7:0]  s_prior_light,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_result_kind,
    output logic [5:0]  m_out_style,
    output logic [8:0]  m_style_level,
    output logic [7:0]  m_entity_light,
    output logic        m_last_result
);
    llps_pkg::llps_cmd_t  cmd;
    llps_pkg::llps_stat_t stat;

    llps_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready, .cmd, .stat
    );

    llps_datapath #(
        .USER_STYLES(USER_STYLES), .ALL_STYLES(ALL_STYLES), .PATTERN_LEN(PATTERN_LEN),
        .FRAC_BITS(FRAC_BITS), .MAX_LEAVES(MAX_LEAVES)
    ) u_dp (
        .aclk, .aresetn, .cmd, .stat,
        .s_opcode, .s_style_index, .s_pattern_level, .s_pattern_end, .s_tick_time,
        .s_lightmap_a, .s_leaf_style_a, .s_lightmap_b, .s_leaf_style_b, .s_leaf_final,
        .s_flash_flag, .s_prior_light,
        .m_result_kind, .m_out_style, .m_style_level, .m_entity_light, .m_last_result
    );

    // An entity light result never carries a style or a level.
    a_entity_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_result_kind) |-> (m_out_style == 6'd0 && m_style_level == 9'd0))
        else $error("entity result carries style data");

    // A new input is never taken while a result waits without being taken.
    a_no_accept_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("input accepted while result stalled");

    // An entity light result is always the last of its item.
    a_entity_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_result_kind) |-> m_last_result)
        else $error("entity result not marked last");
endmodule

/* rtl/llps_datapath.sv */
// Datapath of the light level pattern sequencer: pattern memory, level table,
// shared restoring divider, leaf accumulator and output register. Uses llps_pkg.
module llps_datapath #(
    parameter int USER_STYLES = llps_pkg::USER_STYLES_DEF,
    parameter int ALL_STYLES  = llps_pkg::ALL_STYLES_DEF,
    parameter int PATTERN_LEN = llps_pkg::PATTERN_LEN_DEF,
    parameter int FRAC_BITS   = llps_pkg::FRAC_BITS_DEF,
    parameter int MAX_LEAVES  = llps_pkg::MAX_LEAVES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  llps_pkg::llps_cmd_t cmd,
    output llps_pkg::llps_stat_t stat,
    input  logic [2:0]          s_opcode,
    input  logic [5:0]          s_style_index,
    input  logic [4:0]          s_pattern_level,
    input  logic                s_pattern_end,
    input  logic [27:0]         s_tick_time,
    input  logic [7:0]          s_lightmap_a,
    input  logic [6:0]          s_leaf_style_a,
    input  logic [7:0]          s_lightmap_b,
    input  logic [6:0]          s_leaf_style_b,
    input  logic                s_leaf_final,
    input  logic                s_flash_flag,
    input  logic [7:0]          s_prior_light,
    output logic                m_result_kind,
    output logic [5:0]          m_out_style,
    output logic [8:0]          m_style_level,
    output logic [7:0]          m_entity_light,
    output logic                m_last_result
);
    localparam int SW     = (USER_STYLES > 1) ? $clog2(USER_STYLES) : 1;
    localparam int PW     = $clog2(PATTERN_LEN);
    localparam int LW     = $clog2(ALL_STYLES);
    localparam int MEM_D  = USER_STYLES * PATTERN_LEN;
    localparam int AW     = $clog2(MEM_D);
    localparam int NOUT   = (USER_STYLES < llps_pkg::RESULT_MAX) ? USER_STYLES
                                                                 : llps_pkg::RESULT_MAX;
    localparam int STEPW  = 32;   // (2^28-1)*10 fits in 32 bits
    localparam int CW     = $clog2(MAX_LEAVES + 1);

    // Captured transaction.
    logic [2:0]  op_reg;
    logic [5:0]  sty_reg;
    logic [4:0]  let_reg;
    logic        end_reg, fin_reg, fl_reg;
    logic [27:0] time_reg;
    logic [7:0]  wa_reg, wb_reg, prior_reg;
    logic [6:0]  sa_reg, sb_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg <= s_opcode;     sty_reg <= s_style_index; let_reg <= s_pattern_level;
            end_reg <= s_pattern_end; time_reg <= s_tick_time; wa_reg <= s_lightmap_a;
            sa_reg <= s_leaf_style_a; wb_reg <= s_lightmap_b; sb_reg <= s_leaf_style_b;
            fin_reg <= s_leaf_final; fl_reg <= s_flash_flag; prior_reg <= s_prior_light;
        end
    end

    // Pattern memory and lengths.
    logic [4:0]    pmem [MEM_D];
    logic [4:0]    rd_reg;
    logic [PW-1:0] plen_reg [USER_STYLES];
    logic [PW-1:0] lptr_reg;
    logic [SW-1:0] cur_reg;
    logic [STEPW-1:0] step_reg;

    // Level table: a memory with one valid flag per entry, so that an entry never
    // written since reset weighs as zero. Leaf weights are read when the transaction
    // is captured, as no level is written while the block is idle.
    logic [8:0]            lvl_mem [ALL_STYLES];
    logic [ALL_STYLES-1:0] lvl_vld_reg;
    logic [8:0]            rla_reg, rlb_reg;
    logic                  rva_reg, rvb_reg;
    logic [8:0]            tick_lvl;
    logic                  dir_ok;

    assign tick_lvl = (plen_reg[cur_reg] == '0) ? 9'(llps_pkg::EMPTY_LEVEL)
                                                : llps_pkg::letter_level(rd_reg);
    assign dir_ok   = (7'(sty_reg) >= 7'(USER_STYLES)) && (7'(sty_reg) < 7'(ALL_STYLES));

    always_ff @(posedge aclk) begin
        if (cmd.do_direct && dir_ok)
            lvl_mem[LW'(sty_reg)] <= llps_pkg::letter_level(let_reg);
        if (cmd.tick_write)
            lvl_mem[LW'(cur_reg)] <= tick_lvl;
        if (cmd.capture) begin
            rla_reg <= lvl_mem[LW'(s_leaf_style_a)];
            rlb_reg <= lvl_mem[LW'(s_leaf_style_b)];
            rva_reg <= lvl_vld_reg[LW'(s_leaf_style_a)];
            rvb_reg <= lvl_vld_reg[LW'(s_leaf_style_b)];
        end
    end

    // Shared restoring divider: quotient and remainder of dividend by divisor.
    logic [STEPW-1:0] dq_reg;
    logic [PW+16:0]   rem_reg;
    logic [16:0]      dsor_reg;
    logic [5:0]       dcnt_reg;
    logic             dbusy_reg;
    logic [PW+17:0]   trial;

    logic user_ld;
    assign user_ld = (6'(sty_reg) < 6'(USER_STYLES)) || (USER_STYLES >= 64);

    always_ff @(posedge aclk) begin
        if (cmd.do_load && user_ld && lptr_reg < PW'(PATTERN_LEN - 1))
            pmem[AW'(sty_reg[SW-1:0]) * AW'(PATTERN_LEN) + AW'(lptr_reg)] <= let_reg;
        if (cmd.mem_read)
            rd_reg <= pmem[AW'(cur_reg) * AW'(PATTERN_LEN) + AW'(rem_reg[PW-1:0])];
    end

    logic [PW-1:0] lptr_inc;
    assign lptr_inc = (lptr_reg < PW'(PATTERN_LEN - 1)) ? lptr_reg + 1'b1 : lptr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lptr_reg <= '0;
            for (int i = 0; i < USER_STYLES; i++) plen_reg[i] <= '0;
            lvl_vld_reg <= '0;
        end else begin
            if (cmd.do_load) begin
                if (user_ld && end_reg) plen_reg[sty_reg[SW-1:0]] <= user_ld ? lptr_inc : lptr_reg;
                if (end_reg) lptr_reg <= '0;
                else if (user_ld) lptr_reg <= lptr_inc;
            end
            if (cmd.do_direct && dir_ok)
                lvl_vld_reg[LW'(sty_reg)] <= 1'b1;
            if (cmd.tick_write)
                lvl_vld_reg[LW'(cur_reg)] <= 1'b1;
        end
    end

    // Leaf accumulation.
    logic [15:0]  sum_reg;
    logic [CW-1:0] cnt_reg;
    logic [16:0]  pa_reg, pb_reg;
    logic [8:0]   wla, wlb;
    assign wla = ((7'(sa_reg) < 7'(ALL_STYLES)) && rva_reg) ? rla_reg : '0;
    assign wlb = ((7'(sb_reg) < 7'(ALL_STYLES)) && rvb_reg) ? rlb_reg : '0;

    logic [17:0] light;
    assign light = 18'(pa_reg) + 18'(pb_reg);

    always_ff @(posedge aclk) begin
        if (cmd.leaf_mul) begin
            pa_reg <= 17'(wa_reg) * 17'(wla);
            pb_reg <= 17'(wb_reg) * 17'(wlb);
        end
    end

    assign trial = {rem_reg, dq_reg[STEPW-1]} - {(PW+1)'(0), dsor_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0; cnt_reg <= '0; dbusy_reg <= 1'b0; cur_reg <= '0;
        end else begin
            if (cmd.leaf_acc && cnt_reg < CW'(MAX_LEAVES)) begin
                sum_reg <= sum_reg + 16'(light[17:8]);
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.out_avg) begin
                sum_reg <= '0; cnt_reg <= '0;
            end
            if (cmd.tick_start) begin
                step_reg <= STEPW'((33'(time_reg) * 33'(llps_pkg::TIME_SCALE)) >> FRAC_BITS);
                cur_reg  <= '0;
            end
            if (cmd.tick_write) cur_reg <= cur_reg + 1'b1;
            if (cmd.div_start) begin
                dq_reg    <= step_reg;
                dsor_reg  <= 17'(plen_reg[cur_reg]);
                rem_reg   <= '0;
                dcnt_reg  <= '0;
                dbusy_reg <= (plen_reg[cur_reg] != '0);
            end
            if (cmd.avg_start) begin
                dq_reg    <= {sum_reg, 16'd0};
                dsor_reg  <= 17'(cnt_reg);
                rem_reg   <= '0;
                dcnt_reg  <= 6'd16;
                dbusy_reg <= (cnt_reg != '0);
            end
            if (cmd.div_step && dbusy_reg) begin
                if (!trial[PW+17]) begin
                    rem_reg <= trial[PW+16:0];
                    dq_reg  <= {dq_reg[STEPW-2:0], 1'b1};
                end else begin
                    rem_reg <= {rem_reg[PW+15:0], dq_reg[STEPW-1]};
                    dq_reg  <= {dq_reg[STEPW-2:0], 1'b0};
                end
                dcnt_reg <= dcnt_reg + 1'b1;
                if (dcnt_reg == 6'(STEPW - 1)) dbusy_reg <= 1'b0;
            end
        end
    end

    assign stat.opcode     = op_reg;
    assign stat.final_leaf = fin_reg;
    assign stat.div_done   = !dbusy_reg;
    assign stat.style_last = (32'(cur_reg) == 32'(USER_STYLES - 1));
    assign stat.emit_last  = (32'(cur_reg) == 32'(NOUT - 1));
    assign stat.emit_ok    = (32'(cur_reg) < 32'(NOUT));

    // Output register.
    logic [8:0] boost;
    logic [7:0] avg;
    assign boost = 9'(prior_reg) + 9'(llps_pkg::FLASH_BOOST);
    // Average quotient sits in low 16 bits of the shifted register; zero count gives zero.
    assign avg = (cnt_reg == '0) ? 8'd0 :
                 (dq_reg[15:8] != 8'd0) ? 8'(llps_pkg::LIGHT_MAX) : dq_reg[7:0];

    always_ff @(posedge aclk) begin
        if (cmd.out_style) begin
            m_result_kind <= 1'b0; m_out_style <= 6'(cur_reg); m_entity_light <= '0;
            m_style_level <= tick_lvl; m_last_result <= stat.emit_last;
        end
        if (cmd.out_entity) begin
            m_result_kind <= 1'b1; m_out_style <= '0; m_style_level <= '0;
            m_last_result <= 1'b1;
            m_entity_light <= !fl_reg ? 8'd0 : boost[8] ? 8'(llps_pkg::LIGHT_MAX) : boost[7:0];
        end
        if (cmd.out_avg) begin
            m_result_kind <= 1'b1; m_out_style <= '0; m_style_level <= '0;
            m_last_result <= 1'b1; m_entity_light <= avg;
        end
    end
endmodule

/* rtl/llps_ctrl.sv */
// Controller state machine of the light level pattern sequencer.
// Drives llps_datapath through llps_pkg::llps_cmd_t and reads its status.
module llps_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    output llps_pkg::llps_cmd_t  cmd,
    input  llps_pkg::llps_stat_t stat
);
    localparam logic [3:0] ST_IDLE = 4'd0, ST_DEC = 4'd1, ST_DIV = 4'd2, ST_RD = 4'd3,
                           ST_WR = 4'd4, ST_EMIT = 4'd5, ST_EWAIT = 4'd6, ST_MUL = 4'd7,
                           ST_ACC = 4'd8, ST_AVG = 4'd9, ST_ADIV = 4'd10, ST_OUT = 4'd11,
                           ST_DSET = 4'd12;

    logic [3:0] state_reg, state_next;
    logic       mv_reg, mv_next;

    assign s_ready = aresetn && (state_reg == ST_IDLE) && (!mv_reg || m_ready);
    assign m_valid = mv_reg;

    always_comb begin
        state_next = state_reg;
        mv_next    = mv_reg && !m_ready;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DEC;
                end
            end
            ST_DEC: begin
                case (stat.opcode)
                    llps_pkg::OP_LOAD:   begin cmd.do_load = 1'b1; state_next = ST_IDLE; end
                    llps_pkg::OP_DIRECT: begin cmd.do_direct = 1'b1; state_next = ST_IDLE; end
                    llps_pkg::OP_TICK:   begin cmd.tick_start = 1'b1; state_next = ST_DSET; end
                    llps_pkg::OP_LEAF:   state_next = ST_MUL;
                    llps_pkg::OP_ENTITY: state_next = ST_OUT;
                    default:             state_next = ST_IDLE;
                endcase
            end
            ST_DSET: begin cmd.div_start = 1'b1; state_next = ST_DIV; end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_done) begin cmd.div_step = 1'b0; state_next = ST_RD; end
            end
            ST_RD: begin cmd.mem_read = 1'b1; state_next = ST_WR; end
            ST_WR: begin
                if (!mv_reg || m_ready) begin
                    cmd.tick_write = 1'b0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // Level is written in ST_EWAIT and, if within the result limit, presented together.
                state_next = ST_EWAIT;
            end
            ST_EWAIT: begin
                if (!mv_reg || m_ready) begin
                    cmd.tick_write = 1'b1;
                    if (stat.emit_ok) begin cmd.out_style = 1'b1; mv_next = 1'b1; end
                    state_next = stat.style_last ? ST_IDLE : ST_DSET;
                end
            end
            ST_MUL: begin cmd.leaf_mul = 1'b1; state_next = ST_ACC; end
            ST_ACC: begin
                cmd.leaf_acc = 1'b1;
                state_next = stat.final_leaf ? ST_AVG : ST_IDLE;
            end
            ST_AVG: begin cmd.avg_start = 1'b1; state_next = ST_ADIV; end
            ST_ADIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_done && (!mv_reg || m_ready)) begin
                    cmd.div_step = 1'b0; cmd.out_avg = 1'b1; mv_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (!mv_reg || m_ready) begin
                    cmd.out_entity = 1'b1; mv_next = 1'b1; state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
        end
    end
endmodule
